// ===== design/assert_macros.svh =====
// Assertion macros of the draw engine, used by its top level.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CRDE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CRDE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/crde_pkg.sv =====
// Shared types, constants and span tables of the clipped rectangle draw engine.
// Depends on nothing; used by crde_ctrl, crde_dp and the top level.
package crde_pkg;

   localparam int unsigned DEF_SCREEN_WIDTH  = 160;
   localparam int unsigned DEF_SCREEN_HEIGHT = 128;

   localparam int unsigned COLOR_W = 16;
   localparam int unsigned COORD_W = 16;
   localparam int unsigned PCT_W   = 8;
   localparam int unsigned OP_W    = 3;
   localparam int unsigned STEP_W  = 3;

   // Signed width that holds every span corner and end before clipping.
   localparam int unsigned SPAN_W  = 19;
   // Width times percentage for a positive width, and its quotient by the scale.
   localparam int unsigned PROD_W  = 23;
   localparam int unsigned FRONT_W = 17;

   localparam int unsigned PCT_SCALE   = 100;
   localparam int unsigned RECIP_SHIFT = 30;
   localparam int unsigned RECIP_W     = 24;
   localparam longint unsigned PCT_RECIP = (64'd1 << RECIP_SHIFT) / PCT_SCALE;
   localparam int unsigned SCALED_W = PROD_W + RECIP_W;

   typedef enum logic [OP_W-1:0] {
      OP_PIXEL    = 3'd0,
      OP_HLINE    = 3'd1,
      OP_VLINE    = 3'd2,
      OP_OUTLINE  = 3'd3,
      OP_FILL     = 3'd4,
      OP_PROGRESS = 3'd5,
      OP_READ     = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      SPAN_PIXEL  = 3'd0,
      SPAN_TOP    = 3'd1,
      SPAN_BOTTOM = 3'd2,
      SPAN_LEFT   = 3'd3,
      SPAN_RIGHT  = 3'd4,
      SPAN_FULL   = 3'd5,
      SPAN_BACK   = 3'd6,
      SPAN_FRONT  = 3'd7
   } span_kind_type;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] width;
      logic signed [COORD_W-1:0] height;
      logic [PCT_W-1:0]          percent;
      logic [COLOR_W-1:0]        color;
      logic [COLOR_W-1:0]        back_color;
   } req_payload_type;

   typedef struct packed {
      logic [COLOR_W-1:0] read_color;
      logic               read_valid;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          clear;
      logic          latch;
      logic          mul;
      logic          scale;
      logic          fix;
      logic          setup;
      span_kind_type kind;
      logic          start;
      logic          draw;
      logic          rd_issue;
      logic          load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            empty;
      logic            span_done;
      logic            clear_done;
      logic            rsp_free;
   } sts_type;

   // Span drawn at a given step of a command.
   function automatic span_kind_type span_kind_f(input logic [OP_W-1:0] op,
                                                 input logic [STEP_W-1:0] step);
      span_kind_type k;
      k = SPAN_PIXEL;
      case (op)
         OP_HLINE: begin
            k = SPAN_TOP;
         end
         OP_VLINE: begin
            k = SPAN_LEFT;
         end
         OP_FILL: begin
            k = SPAN_FULL;
         end
         OP_OUTLINE: begin
            case (step)
               3'd0:    k = SPAN_TOP;
               3'd1:    k = SPAN_BOTTOM;
               3'd2:    k = SPAN_LEFT;
               default: k = SPAN_RIGHT;
            endcase
         end
         OP_PROGRESS: begin
            case (step)
               3'd0:    k = SPAN_BACK;
               3'd1:    k = SPAN_FRONT;
               3'd2:    k = SPAN_TOP;
               3'd3:    k = SPAN_BOTTOM;
               3'd4:    k = SPAN_LEFT;
               default: k = SPAN_RIGHT;
            endcase
         end
         default: begin
            k = SPAN_PIXEL;
         end
      endcase
      return k;
   endfunction

   // True when the given step is the final span of the command.
   function automatic logic span_last_f(input logic [OP_W-1:0] op,
                                        input logic [STEP_W-1:0] step);
      logic last;
      last = 1'b1;
      case (op)
         OP_OUTLINE:  last = (step == 3'd3);
         OP_PROGRESS: last = (step == 3'd5);
         default:     last = 1'b1;
      endcase
      return last;
   endfunction

endpackage

// ===== design/crde_ctrl.sv =====
// Controller state machine of the draw engine: sequences clearing, spans and reads.
// Depends on crde_pkg; drives crde_dp through the command struct.
module crde_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output crde_pkg::cmd_type cmd,
   input  crde_pkg::sts_type sts
);

   typedef enum logic [10:0] {
      ST_CLEAR  = 11'b000_0000_0001,
      ST_IDLE   = 11'b000_0000_0010,
      ST_DECODE = 11'b000_0000_0100,
      ST_MUL    = 11'b000_0000_1000,
      ST_SCALE  = 11'b000_0001_0000,
      ST_FIX    = 11'b000_0010_0000,
      ST_SETUP  = 11'b000_0100_0000,
      ST_START  = 11'b000_1000_0000,
      ST_DRAW   = 11'b001_0000_0000,
      ST_READ   = 11'b010_0000_0000,
      ST_FINISH = 11'b100_0000_0000
   } state_type;

   state_type                     state_ff, state_in;
   logic [crde_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                          last_span;
   logic                          is_read;

   assign last_span = crde_pkg::span_last_f(sts.op, step_ff);
   assign is_read   = (sts.op == crde_pkg::OP_READ);

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      cmd.kind  = crde_pkg::span_kind_f(sts.op, step_ff);
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            step_in = '0;
            if (sts.op == crde_pkg::OP_PROGRESS) begin
               state_in = ST_MUL;
            end else if (sts.op <= crde_pkg::OP_READ) begin
               state_in = ST_SETUP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_START;
         end
         ST_START: begin
            cmd.start = 1'b1;
            if (sts.empty) begin
               if (last_span) begin
                  state_in = ST_FINISH;
               end else begin
                  step_in  = step_ff + 3'd1;
                  state_in = ST_SETUP;
               end
            end else if (is_read) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            cmd.draw = 1'b1;
            if (sts.span_done) begin
               if (last_span) begin
                  state_in = ST_FINISH;
               end else begin
                  step_in  = step_ff + 3'd1;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== design/crde_dp.sv =====
// Datapath of the draw engine: command registers, span clipping, pixel cursor,
// progress divider, frame store and result register. Depends on crde_pkg.
module crde_dp #(
   parameter int unsigned SCREEN_WIDTH  = crde_pkg::DEF_SCREEN_WIDTH,
   parameter int unsigned SCREEN_HEIGHT = crde_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  crde_pkg::req_payload_type req_payload,
   input  crde_pkg::cmd_type         cmd,
   output crde_pkg::sts_type         sts,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output crde_pkg::rsp_payload_type rsp_payload
);

   localparam int unsigned DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned XW    = $clog2(SCREEN_WIDTH + 1);
   localparam int unsigned YW    = $clog2(SCREEN_HEIGHT + 1);
   localparam int unsigned SPW   = crde_pkg::SPAN_W;
   localparam int unsigned CW    = crde_pkg::COLOR_W;
   localparam int unsigned PW    = crde_pkg::PROD_W;
   localparam int unsigned FW    = crde_pkg::FRONT_W;
   localparam int unsigned MW    = crde_pkg::SCALED_W;
   localparam int unsigned EXT   = SPW - crde_pkg::COORD_W;
   localparam logic signed [SPW-1:0] SW_S = SPW'(SCREEN_WIDTH);
   localparam logic signed [SPW-1:0] SH_S = SPW'(SCREEN_HEIGHT);
   localparam logic signed [SPW-1:0] ONE_S = SPW'(1);

   // Latched command fields.
   logic [crde_pkg::OP_W-1:0]           op_ff;
   logic signed [crde_pkg::COORD_W-1:0] x_ff, y_ff, w_ff, h_ff;
   logic [crde_pkg::PCT_W-1:0]          pct_ff;
   logic [CW-1:0]                       color_ff, back_ff;

   // Progress front width.
   logic [PW-1:0]  prod_ff, rem;
   logic [MW-1:0]  scaled;
   logic [FW-1:0]  qest_ff, front_ff;

   // Span clipping.
   logic signed [SPW-1:0] ext_x, ext_y, ext_w, ext_h, ext_front;
   logic signed [SPW-1:0] sx, sy, sw, sh, x0, y0, x_end, y_end, x1, y1;
   logic                  empty_c;
   logic [XW-1:0]         x0_ff, x1_ff, x_last;
   logic [YW-1:0]         y0_ff, y1_ff, y_last;
   logic                  empty_ff;
   logic [CW-1:0]         span_color_ff;

   // Pixel cursor.
   logic [XW-1:0] cx_ff;
   logic [YW-1:0] cy_ff;
   logic [AW-1:0] row_base_ff, pix_addr;

   // Frame store.
   logic [CW-1:0] mem [DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_waddr, clr_ff;
   logic [CW-1:0] mem_wdata, rd_data_ff;
   logic          read_hit_ff;

   logic                      rsp_valid_ff;
   crde_pkg::rsp_payload_type rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= req_payload.op;
         x_ff     <= req_payload.pos_x;
         y_ff     <= req_payload.pos_y;
         w_ff     <= req_payload.width;
         h_ff     <= req_payload.height;
         pct_ff   <= req_payload.percent;
         color_ff <= req_payload.color;
         back_ff  <= req_payload.back_color;
      end
   end

   // Front width = width * percent / 100, reciprocal multiply with one correction.
   assign scaled = MW'(prod_ff) * MW'(crde_pkg::PCT_RECIP);
   assign rem    = prod_ff - PW'(qest_ff) * PW'(crde_pkg::PCT_SCALE);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         if (!w_ff[crde_pkg::COORD_W-1] && (w_ff != '0)) begin
            prod_ff <= PW'(w_ff[crde_pkg::COORD_W-2:0]) * PW'(pct_ff);
         end else begin
            prod_ff <= '0;
         end
      end
      if (cmd.scale) begin
         qest_ff <= scaled[crde_pkg::RECIP_SHIFT +: FW];
      end
      if (cmd.latch) begin
         front_ff <= '0;
      end else if (cmd.fix) begin
         front_ff <= (rem >= PW'(crde_pkg::PCT_SCALE)) ? qest_ff + FW'(1) : qest_ff;
      end
   end

   assign ext_x     = {{EXT{x_ff[crde_pkg::COORD_W-1]}}, x_ff};
   assign ext_y     = {{EXT{y_ff[crde_pkg::COORD_W-1]}}, y_ff};
   assign ext_w     = {{EXT{w_ff[crde_pkg::COORD_W-1]}}, w_ff};
   assign ext_h     = {{EXT{h_ff[crde_pkg::COORD_W-1]}}, h_ff};
   assign ext_front = SPW'(front_ff);

   always_comb begin
      sx = ext_x;
      sy = ext_y;
      sw = ONE_S;
      sh = ONE_S;
      case (cmd.kind)
         crde_pkg::SPAN_TOP: begin
            sw = ext_w;
         end
         crde_pkg::SPAN_BOTTOM: begin
            sy = ext_y + ext_h - ONE_S;
            sw = ext_w;
         end
         crde_pkg::SPAN_LEFT: begin
            sh = ext_h;
         end
         crde_pkg::SPAN_RIGHT: begin
            sx = ext_x + ext_w - ONE_S;
            sh = ext_h;
         end
         crde_pkg::SPAN_FULL, crde_pkg::SPAN_BACK: begin
            sw = ext_w;
            sh = ext_h;
         end
         crde_pkg::SPAN_FRONT: begin
            sw = ext_front;
            sh = ext_h;
         end
         default: begin
            sw = ONE_S;
            sh = ONE_S;
         end
      endcase
      x0      = sx[SPW-1] ? '0 : sx;
      y0      = sy[SPW-1] ? '0 : sy;
      x_end   = sx + sw;
      y_end   = sy + sh;
      x1      = (x_end > SW_S) ? SW_S : x_end;
      y1      = (y_end > SH_S) ? SH_S : y_end;
      empty_c = (x0 >= x1) || (y0 >= y1);
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         x0_ff         <= x0[XW-1:0];
         x1_ff         <= x1[XW-1:0];
         y0_ff         <= y0[YW-1:0];
         y1_ff         <= y1[YW-1:0];
         empty_ff      <= empty_c;
         span_color_ff <= (cmd.kind == crde_pkg::SPAN_BACK) ? back_ff : color_ff;
      end
   end

   assign x_last   = x1_ff - XW'(1);
   assign y_last   = y1_ff - YW'(1);
   assign pix_addr = row_base_ff + AW'(cx_ff);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cx_ff       <= x0_ff;
         cy_ff       <= y0_ff;
         row_base_ff <= AW'(32'(y0_ff) * SCREEN_WIDTH);
      end else if (cmd.draw) begin
         if (cx_ff == x_last) begin
            cx_ff       <= x0_ff;
            cy_ff       <= cy_ff + YW'(1);
            row_base_ff <= row_base_ff + AW'(SCREEN_WIDTH);
         end else begin
            cx_ff <= cx_ff + XW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   assign mem_we    = cmd.clear || cmd.draw;
   assign mem_waddr = cmd.clear ? clr_ff : pix_addr;
   assign mem_wdata = cmd.clear ? '0 : span_color_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[pix_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_hit_ff <= 1'b0;
      end else if (cmd.latch) begin
         read_hit_ff <= 1'b0;
      end else if (cmd.rd_issue) begin
         read_hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_payload_ff.read_color <= read_hit_ff ? rd_data_ff : '0;
         rsp_payload_ff.read_valid <= read_hit_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign sts.op         = op_ff;
   assign sts.empty      = empty_ff;
   assign sts.span_done  = (cx_ff == x_last) && (cy_ff == y_last);
   assign sts.clear_done = (clr_ff == AW'(DEPTH - 1));
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== design/clipped_rect_draw_engine.sv =====
// Top level of the clipped rectangle draw engine.
// Depends on crde_pkg, crde_ctrl, crde_dp and assert_macros.svh.
//
// Usage. Drawing and read commands arrive on the req_ channel, one transaction
// per command; every command returns exactly one transaction on the rsp_
// channel, carrying the stored pixel for an on-screen read and zeros otherwise.
// A transaction moves at a rising edge where valid is high and stall is low.
// Each command splits into clipped spans: one for pixel, line, fill and read,
// four for an outline, six for a progress bar. Every span passes through a set-up
// and a start state, after which the single write port of the frame store takes
// one pixel per cycle. A progress bar first works out its front width in the
// multiply, scale and fix states, and an on-screen read fetches its pixel in the
// read state. The next command is taken in the cycle after the result is loaded:
// req_stall is low only while the engine is idle.
// After reset the engine sweeps all SCREEN_WIDTH * SCREEN_HEIGHT pixels (20480
// by default) of the frame store to zero, one pixel per cycle, holding req_stall
// high throughout. The result sits in an output register: while the receiver
// stalls it the engine may still finish the next command, and then waits with
// that result until the register is freed.
`include "assert_macros.svh"

module clipped_rect_draw_engine #(
   parameter int unsigned SCREEN_WIDTH  = crde_pkg::DEF_SCREEN_WIDTH,
   parameter int unsigned SCREEN_HEIGHT = crde_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  crde_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output crde_pkg::rsp_payload_type rsp_payload
);

   // Command and status groups between the controller and the datapath.
   crde_pkg::cmd_type cmd;
   crde_pkg::sts_type sts;

   // The controller walks each command through its spans and raises the
   // command strobes for the datapath, never two at once.
   crde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath clips spans, steps the pixel cursor, owns the frame store
   // and holds the result register.
   crde_dp #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A new result is only loaded when the output register is free.
   `CRDE_ASSERT_IMP(a_load_free, clock, reset, cmd.load_rsp, !rsp_valid || !rsp_stall, "result overwritten")
   // The frame store is never written while the engine is open for a command.
   `CRDE_ASSERT_IMP(a_idle_no_write, clock, reset, !req_stall, !cmd.draw && !cmd.clear, "write while idle")
   // Every accepted transaction is latched into the datapath.
   `CRDE_ASSERT_IMP(a_accept_latch, clock, reset, req_valid && !req_stall, cmd.latch, "command not latched")
   // A taken result with nothing new behind it leaves the output empty.
   `CRDE_ASSERT_NXT(a_rsp_drain, clock, reset, rsp_valid && !rsp_stall && !cmd.load_rsp, !rsp_valid, "result repeated")

endmodule
